// ----- rtl/svoc_pkg.sv -----
// ============================================================================
// svoc_pkg - shared definitions for the strided view overlap checker
// Defaults for the width parameters and the result word layout.
// ============================================================================
package svoc_pkg;

  // Default field widths
  localparam int INDEX_WIDTH_DEF  = 31;
  localparam int STRIDE_WIDTH_DEF = 32;

  // Result word layout on out_tdata
  localparam int OUT_TDATA_W  = 8;
  localparam int OVERLAP_BIT  = 0;
  localparam int NOT_MULT_BIT = 1;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- rtl/svoc_div.sv -----
// ============================================================================
// svoc_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle. Quotient and remainder
// are valid in the cycle that done is high.
// ============================================================================
module svoc_div #(
  parameter int WIDTH = svoc_pkg::STRIDE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [WIDTH:0] shifted;
  logic [WIDTH:0] trial;
  logic           fits;

  assign shifted = {rem_r, quo_r[WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/strided_view_overlap_check_unit.sv -----
// ============================================================================
// strided_view_overlap_check_unit - overlap test for two strided views
// Takes one dimension per input transaction and reports, on the dimension
// flagged by tlast, whether two views of one base tensor may overlap.
// ============================================================================
// Each input transaction carries one dimension of a view pair; in_tlast marks
// the final one, and that transaction alone yields a result. The unit is
// busy with one transaction at a time (in_tready low meanwhile). It first
// forms four products on one shared multiplier. The single shared radix-2
// divider then runs the dilation quotient a_stride/base_stride and, when the
// dilation exceeds one, the a_start and b_start modulos back to back; a zero
// base_stride skips the divider. A fold step then merges the dimension into
// the running flags; the divider is DW = max(INDEX_WIDTH, STRIDE_WIDTH) wide.
// The verdict sits in an output register, so the next transaction is taken
// while a result waits; a final dimension stalls only if the previous verdict
// has not been taken yet. Result bits: overlap (plain interval test, or the
// dilated test when the view strides match each other everywhere and differ
// from the base somewhere) and stride_not_multiple (dilated test in use and
// some a_stride was not a whole multiple of base_stride).
// ============================================================================
module strided_view_overlap_check_unit #(
  parameter int  INDEX_WIDTH  = svoc_pkg::INDEX_WIDTH_DEF,
  parameter int  STRIDE_WIDTH = svoc_pkg::STRIDE_WIDTH_DEF,
  localparam int IN_TDATA_W   = ((4 * INDEX_WIDTH + 3 * STRIDE_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // a_start, a_size, a_stride, b_start, b_size, b_stride, base_stride
  input  logic [IN_TDATA_W-1:0]        in_tdata,
  input  logic                         in_tlast,   // last_dim
  // Result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // overlap, stride_not_multiple, zero fill
  output logic [svoc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int IW = INDEX_WIDTH;
  localparam int SW = STRIDE_WIDTH;
  localparam int DW = svoc_pkg::max_int(IW, SW);
  localparam int PW = IW + 1 + SW;

  // Field offsets in in_tdata
  localparam int A_START_LO = 0;
  localparam int A_SIZE_LO  = A_START_LO + IW;
  localparam int A_STR_LO   = A_SIZE_LO + IW;
  localparam int B_START_LO = A_STR_LO + SW;
  localparam int B_SIZE_LO  = B_START_LO + IW;
  localparam int B_STR_LO   = B_SIZE_LO + IW;
  localparam int G_STR_LO   = B_STR_LO + SW;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,   // four products, one per cycle
    ST_DQ   = 6'b000100,   // dilation = a_stride / base_stride
    ST_DA   = 6'b001000,   // a_start mod dilation
    ST_DB   = 6'b010000,   // b_start mod dilation
    ST_FOLD = 6'b100000    // fold dimension into running flags
  } state_t;

  localparam logic [1:0] MUL_LAST = 2'd3;

  state_t state_r, state_nxt;

  // Captured dimension
  logic [IW-1:0] as_r, bs_r;
  logic [IW:0]   asum_r, bsum_r;
  logic [SW-1:0] ad_r, bd_r, gd_r;
  logic          last_r;

  // Products: a_end, b_begin, a_begin, b_end
  logic [PW-1:0] prod_r [4];
  logic [1:0]    mcnt_r, mcnt_nxt;
  logic [IW:0]   mul_a;
  logic [SW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  // Dilation results
  logic [SW-1:0] dil_r, ra_r;
  logic          dfrac_r, dfrac_nxt;
  logic          mmiss_r, mmiss_nxt;

  // Running flags
  logic plain_r, dilhit_r, same_r, base_r, frac_r;
  logic plain_nxt, dilhit_nxt, same_nxt, base_nxt, frac_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [svoc_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Shared divider
  logic          div_start;
  logic [DW-1:0] div_dvd, div_dvs, div_quo, div_rem;
  logic          div_done;

  svoc_div #(.WIDTH(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  logic in_fire;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Shared multiplier operand select
  always_comb begin
    case (mcnt_r)
      2'd0:    begin mul_a = asum_r;           mul_b = ad_r; end
      2'd1:    begin mul_a = {1'b0, bs_r};     mul_b = bd_r; end
      2'd2:    begin mul_a = {1'b0, as_r};     mul_b = ad_r; end
      default: begin mul_a = bsum_r;           mul_b = bd_r; end
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Per-dimension verdicts
  logic dim_hit, dil_ok, fold_go, use_dil;
  assign dim_hit = !(prod_r[0] <= prod_r[1]) && !(prod_r[2] >= prod_r[3]);
  assign dil_ok  = dim_hit && !mmiss_r;
  assign fold_go = !(last_r && out_valid_r && !out_tready);

  always_comb begin
    plain_nxt  = plain_r  & dim_hit;
    dilhit_nxt = dilhit_r & dil_ok;
    same_nxt   = same_r   & (ad_r == bd_r);
    base_nxt   = base_r   & (ad_r == gd_r);
    frac_nxt   = frac_r   | dfrac_r;
    use_dil    = same_nxt & !base_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mcnt_nxt      = mcnt_r;
    dfrac_nxt     = dfrac_r;
    mmiss_nxt     = mmiss_r;
    div_start     = 1'b0;
    div_dvd       = DW'(ad_r);
    div_dvs       = DW'(gd_r);
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
          mcnt_nxt  = '0;
          dfrac_nxt = 1'b0;
          mmiss_nxt = 1'b0;
        end
      end
      ST_MUL: begin
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == MUL_LAST) begin
          if (gd_r == '0) begin
            // zero base stride: error, no modulo check
            dfrac_nxt = 1'b1;
            state_nxt = ST_FOLD;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DQ;
          end
        end
      end
      ST_DQ: begin
        if (div_done) begin
          dfrac_nxt = (div_rem != '0);
          if (div_quo > DW'(1)) begin
            div_start = 1'b1;
            div_dvd   = DW'(as_r);
            div_dvs   = div_quo;
            state_nxt = ST_DA;
          end else begin
            state_nxt = ST_FOLD;
          end
        end
      end
      ST_DA: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = DW'(bs_r);
          div_dvs   = DW'(dil_r);
          state_nxt = ST_DB;
        end
      end
      ST_DB: begin
        if (div_done) begin
          mmiss_nxt = (ra_r != div_rem[SW-1:0]);
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (fold_go) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt[svoc_pkg::OVERLAP_BIT]  = use_dil ? dilhit_nxt : plain_nxt;
            out_data_nxt[svoc_pkg::NOT_MULT_BIT] = use_dil & frac_nxt;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
      plain_r     <= 1'b1;
      dilhit_r    <= 1'b1;
      same_r      <= 1'b1;
      base_r      <= 1'b1;
      frac_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_FOLD && fold_go) begin
        if (last_r) begin
          // verdict issued: back to cleared flags
          plain_r  <= 1'b1;
          dilhit_r <= 1'b1;
          same_r   <= 1'b1;
          base_r   <= 1'b1;
          frac_r   <= 1'b0;
        end else begin
          plain_r  <= plain_nxt;
          dilhit_r <= dilhit_nxt;
          same_r   <= same_nxt;
          base_r   <= base_nxt;
          frac_r   <= frac_nxt;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    dfrac_r    <= dfrac_nxt;
    mmiss_r    <= mmiss_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      as_r   <= in_tdata[A_START_LO +: IW];
      bs_r   <= in_tdata[B_START_LO +: IW];
      asum_r <= (IW+1)'(in_tdata[A_START_LO +: IW]) + (IW+1)'(in_tdata[A_SIZE_LO +: IW]);
      bsum_r <= (IW+1)'(in_tdata[B_START_LO +: IW]) + (IW+1)'(in_tdata[B_SIZE_LO +: IW]);
      ad_r   <= in_tdata[A_STR_LO +: SW];
      bd_r   <= in_tdata[B_STR_LO +: SW];
      gd_r   <= in_tdata[G_STR_LO +: SW];
      last_r <= in_tlast;
    end
    if (state_r == ST_MUL) begin
      prod_r[mcnt_r] <= mul_p;
    end
    if (state_r == ST_DQ && div_done) begin
      dil_r <= div_quo[SW-1:0];
    end
    if (state_r == ST_DA && div_done) begin
      ra_r <= div_rem[SW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/svoc_chk.sv -----
// ============================================================================
// svoc_chk - port-level checks for the strided view overlap checker
// Watches the top-level handshakes and result word over time.
// ============================================================================
module svoc_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [svoc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // A transaction keeps the unit busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an input transaction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Fill bits of the result word stay zero
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[svoc_pkg::OUT_TDATA_W-1:svoc_pkg::NOT_MULT_BIT+1] == '0)
    else $error("result fill bits not zero");

  // A new result is posted as the unit returns to ready
  a_result_with_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result appeared while unit still busy");

endmodule

bind strided_view_overlap_check_unit svoc_chk u_svoc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
